>>> rtl/max_heap_priority_queue_defines.svh
`ifndef MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// checked only outside reset
`define MHPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// checked at every edge, reset included
`define MHPQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> rtl/mhpq_pkg.sv
`timescale 1ns / 1ps

package mhpq_pkg;

    localparam int CAPACITY   = 64;
    localparam int KEY_W      = 32;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int IN_DATA_W  = ((KEY_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((KEY_W + CNT_W + 7) / 8) * 8;
    localparam int STATUS_W   = 2;

    typedef enum logic [0:0] {
        ACT_INSERT = 1'b0,
        ACT_DELETE = 1'b1
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    // shift command broadcast along the row
    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_op;

endpackage

>>> rtl/mhpq_cell.sv
`timescale 1ns / 1ps

module mhpq_cell (
    input  logic                                  i_clk,
    input  mhpq_pkg::t_cell_op                    i_op,
    input  logic signed [mhpq_pkg::KEY_W-1:0]     i_key,
    input  logic signed [mhpq_pkg::KEY_W-1:0]     i_left_key,
    input  logic                                  i_left_gt,
    input  logic signed [mhpq_pkg::KEY_W-1:0]     i_right_key,
    input  logic                                  i_occ,
    output logic signed [mhpq_pkg::KEY_W-1:0]     o_key,
    output logic                                  o_gt
);

    logic signed [mhpq_pkg::KEY_W-1:0] r_key;
    logic signed [mhpq_pkg::KEY_W-1:0] n_key;

    // new key belongs at or before this cell
    assign o_gt  = !i_occ || (i_key > r_key);
    assign o_key = r_key;

    always_comb begin
        n_key = r_key;
        if (i_op.ins) begin
            if (i_left_gt) begin
                n_key = i_left_key;
            end else if (o_gt) begin
                n_key = i_key;
            end
        end else if (i_op.del) begin
            n_key = i_right_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

>>> rtl/max_heap_priority_queue.sv
`timescale 1ns / 1ps
// the result word of an accepted word is registered and appears on the master side in the cycle after acceptance
// throughput: one word per cycle while the master side keeps taking results
// every cell of the sorted row compares and shifts in the accepting cycle
// reset clears the entry count and the result valid; cell keys are not cleared
// and no clearing pass is needed

`include "max_heap_priority_queue_defines.svh"

module max_heap_priority_queue (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [mhpq_pkg::IN_DATA_W-1:0]     i_s_tdata,  // key_value
    input  logic [0:0]                         i_s_tuser,  // action
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [mhpq_pkg::OUT_DATA_W-1:0]    o_m_tdata,  // removed_key, entries_after
    output logic [mhpq_pkg::STATUS_W-1:0]      o_m_tuser   // status
);

    localparam int CAP = mhpq_pkg::CAPACITY;
    localparam int KW  = mhpq_pkg::KEY_W;
    localparam int CW  = mhpq_pkg::CNT_W;

    logic                       r_out_valid;
    logic signed [KW-1:0]       r_out_key;
    logic signed [KW-1:0]       n_out_key;
    mhpq_pkg::t_status          r_out_status;
    mhpq_pkg::t_status          n_out_status;
    logic [CW-1:0]              r_out_entries;
    logic [CW-1:0]              r_count;
    logic [CW-1:0]              n_count;

    logic                       w_acc;
    mhpq_pkg::t_action          w_action;
    logic signed [KW-1:0]       w_in_key;
    logic                       w_full;
    logic                       w_empty;
    mhpq_pkg::t_cell_op         w_op;

    logic signed [KW-1:0]       w_key [CAP];
    logic [CAP-1:0]             w_gt;
    logic [CAP-1:0]             w_occ;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_action   = mhpq_pkg::t_action'(i_s_tuser[0]);
    assign w_in_key   = i_s_tdata[KW-1:0];
    assign w_full     = (r_count == CW'(CAP));
    assign w_empty    = (r_count == '0);

    assign w_op.ins = w_acc && (w_action == mhpq_pkg::ACT_INSERT) && !w_full;
    assign w_op.del = w_acc && (w_action == mhpq_pkg::ACT_DELETE) && !w_empty;

    // row of cells held in descending order, cell 0 has the maximum
    for (genvar i = 0; i < CAP; i++) begin : g_cell
        logic signed [KW-1:0] w_left_key;
        logic                 w_left_gt;
        logic signed [KW-1:0] w_right_key;

        assign w_occ[i] = (CW'(i) < r_count);

        if (i == 0) begin : g_first
            assign w_left_key = '0;
            assign w_left_gt  = 1'b0;
        end else begin : g_mid
            assign w_left_key = w_key[i-1];
            assign w_left_gt  = w_gt[i-1];
        end

        if (i == CAP - 1) begin : g_last
            assign w_right_key = w_key[i];
        end else begin : g_body
            assign w_right_key = w_key[i+1];
        end

        mhpq_cell u_cell (
            .i_clk       (i_clk),
            .i_op        (w_op),
            .i_key       (w_in_key),
            .i_left_key  (w_left_key),
            .i_left_gt   (w_left_gt),
            .i_right_key (w_right_key),
            .i_occ       (w_occ[i]),
            .o_key       (w_key[i]),
            .o_gt        (w_gt[i])
        );
    end

    always_comb begin
        n_count      = r_count;
        n_out_key    = '0;
        n_out_status = mhpq_pkg::ST_INSERTED;
        if (w_action == mhpq_pkg::ACT_INSERT) begin
            if (w_full) begin
                n_out_status = mhpq_pkg::ST_FULL;
            end else begin
                n_count = r_count + CW'(1);
            end
        end else begin
            if (w_empty) begin
                n_out_status = mhpq_pkg::ST_EMPTY;
            end else begin
                n_count      = r_count - CW'(1);
                n_out_key    = w_key[0];
                n_out_status = mhpq_pkg::ST_REMOVED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else if (w_acc) begin
            r_count     <= n_count;
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_out_key     <= n_out_key;
            r_out_status  <= n_out_status;
            r_out_entries <= n_count;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(mhpq_pkg::OUT_DATA_W - KW - CW){1'b0}}, r_out_entries, r_out_key};
    assign o_m_tuser  = r_out_status;

    `MHPQ_ASSERT_ALWAYS(a_rst_clears_valid, !i_rst_n |=> !r_out_valid, "result valid after reset")
    `MHPQ_ASSERT(a_count_bound, r_count <= CW'(CAP), "entry count beyond capacity")
    `MHPQ_ASSERT(a_row_sorted, (r_count > CW'(1)) |-> (w_key[0] >= w_key[1]), "row head not max")
    `MHPQ_ASSERT(a_ins_count, w_op.ins |=> (r_count == $past(r_count) + CW'(1)), "insert count")
    `MHPQ_ASSERT(a_del_key, w_op.del |=> (r_out_key == $past(w_key[0])), "removed key mismatch")
    `MHPQ_ASSERT(a_empty_zero, (r_out_valid && (r_out_status == mhpq_pkg::ST_EMPTY)) |-> (r_out_entries == '0), "empty with entries")

endmodule

>>> tb/tb_max_heap_priority_queue.sv
`timescale 1ns / 1ps

module tb_max_heap_priority_queue;

    import mhpq_pkg::*;

    localparam int  CYCLE_LIMIT   = 900000;
    localparam int  SETTLE_CYCLES = 4;
    localparam int  RANDOM_ITEMS  = 1500;
    localparam int  MAX_REPORTS   = 10;

    typedef struct {
        logic signed [KEY_W-1:0] removed_key;
        t_status                 status;
        logic [CNT_W-1:0]        entries_after;
    } t_heap_result;

    logic                    i_clk      = 1'b0;
    logic                    i_rst_n    = 1'b0;
    logic                    i_s_tvalid = 1'b0;
    logic                    o_s_tready;
    logic [IN_DATA_W-1:0]    i_s_tdata  = '0;
    logic [0:0]              i_s_tuser  = 1'b0;
    logic                    o_m_tvalid;
    logic                    i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   o_m_tdata;
    logic [STATUS_W-1:0]     o_m_tuser;

    // own copy of the heap, children of slot i at 2i+1 and 2i+2
    logic signed [KEY_W-1:0] heap_keys [CAPACITY];
    int                      heap_count = 0;

    t_heap_result            pending_results [$];
    int                      fail_count  = 0;
    int                      cycle_count = 0;
    int                      words_sent  = 0;
    bit                      src_gaps    = 1'b1;
    bit                      sink_stalls = 1'b1;

    max_heap_priority_queue DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // key_value
        .i_s_tuser  (i_s_tuser),   // action
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),   // removed_key, entries_after
        .o_m_tuser  (o_m_tuser)    // status
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("max_heap_priority_queue regression: fail");
            $finish;
        end
    end

    // applies one operation to the heap copy and returns what the block should answer
    function automatic t_heap_result heap_apply(t_action act, logic signed [KEY_W-1:0] key);
        t_heap_result            res;
        int                      pos;
        int                      parent;
        int                      left;
        int                      right;
        int                      best;
        logic signed [KEY_W-1:0] tmp;
        res.removed_key = '0;
        if (act == ACT_INSERT) begin
            if (heap_count >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                heap_keys[heap_count] = key;
                pos = heap_count;
                while (pos > 0) begin
                    parent = (pos - 1) / 2;
                    if (!(heap_keys[pos] > heap_keys[parent]))
                        break;
                    tmp               = heap_keys[pos];
                    heap_keys[pos]    = heap_keys[parent];
                    heap_keys[parent] = tmp;
                    pos               = parent;
                end
                heap_count++;
                res.status = ST_INSERTED;
            end
        end else begin
            if (heap_count == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.removed_key = heap_keys[0];
                heap_count--;
                heap_keys[0] = heap_keys[heap_count];
                pos = 0;
                while (pos < heap_count) begin
                    left  = 2 * pos + 1;
                    right = 2 * pos + 2;
                    best  = pos;
                    if (left < heap_count && heap_keys[left] > heap_keys[best])
                        best = left;
                    if (right < heap_count && heap_keys[right] > heap_keys[best])
                        best = right;
                    if (best == pos)
                        break;
                    tmp             = heap_keys[pos];
                    heap_keys[pos]  = heap_keys[best];
                    heap_keys[best] = tmp;
                    pos             = best;
                end
                res.status = ST_REMOVED;
            end
        end
        res.entries_after = heap_count[CNT_W-1:0];
        return res;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [KEY_W-1:0] pick_key(int mode);
        case (mode)
            0: begin
                return $urandom();
            end
            1: begin
                // narrow range so that equal keys are common
                return $signed($urandom_range(0, 15)) - 8;
            end
            default: begin
                case ($urandom_range(0, 5))
                    0: return 32'sh7fff_ffff;
                    1: return 32'sh8000_0000;
                    2: return 32'sh7fff_fffe;
                    3: return 32'sh8000_0001;
                    4: return '0;
                    default: return -1;
                endcase
            end
        endcase
    endfunction

    task automatic send_word(t_action act, logic signed [KEY_W-1:0] key);
        int gap;
        gap = src_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= key;
        i_s_tuser  <= act;
        do
            @(posedge i_clk);
        while (!o_s_tready);
        pending_results.push_back(heap_apply(act, key));
        words_sent++;
    endtask

    task automatic settle_phase();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : check_results
        t_heap_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result word: tdata %h tuser %0d", o_m_tdata, o_m_tuser);
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata[KEY_W-1:0] !== want.removed_key
                        || o_m_tuser !== want.status
                        || o_m_tdata[KEY_W+CNT_W-1:KEY_W] !== want.entries_after) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("mismatch: key %h/%h status %0d/%0d entries %0d/%0d (exp/act)",
                                 want.removed_key, o_m_tdata[KEY_W-1:0],
                                 want.status, o_m_tuser,
                                 want.entries_after, o_m_tdata[KEY_W+CNT_W-1:KEY_W]);
                end
            end
        end
    end

    // receiver pacing: ready mostly high, stalls of random length
    initial begin : sink_pacing
        int n;
        forever begin
            @(posedge i_clk);
            if (sink_stalls && $urandom_range(0, 3) == 0) begin
                n = 1 + pick_gap();
                i_m_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
        end
    end

    // extremes, equal keys, delete on an empty heap
    task automatic test_directed();
        send_word(ACT_DELETE, pick_key(0));
        send_word(ACT_INSERT, '0);
        send_word(ACT_INSERT, 32'sh7fff_ffff);
        send_word(ACT_INSERT, 32'sh8000_0000);
        send_word(ACT_INSERT, -1);
        send_word(ACT_INSERT, 1);
        send_word(ACT_INSERT, 32'sh7fff_ffff);
        send_word(ACT_INSERT, 32'sh8000_0000);
        send_word(ACT_DELETE, 32'sh7fff_ffff);
        send_word(ACT_DELETE, '0);
        send_word(ACT_DELETE, -1);
        send_word(ACT_INSERT, 5);
        send_word(ACT_INSERT, 5);
        send_word(ACT_INSERT, 5);
        repeat (8) send_word(ACT_DELETE, pick_key(0));
        send_word(ACT_DELETE, 32'sh8000_0000);
        settle_phase();
    endtask

    // fill to capacity, push past it, then drain past empty
    task automatic test_full_and_drain();
        while (heap_count < CAPACITY)
            send_word(ACT_INSERT, pick_key($urandom_range(0, 2)));
        repeat (3) send_word(ACT_INSERT, pick_key(0));
        send_word(ACT_DELETE, pick_key(0));
        send_word(ACT_INSERT, pick_key(2));
        send_word(ACT_INSERT, pick_key(0));
        while (heap_count > 0)
            send_word(ACT_DELETE, pick_key(0));
        repeat (2) send_word(ACT_DELETE, pick_key(0));
        settle_phase();
    endtask

    // runs of inserts and deletes so the heap swings between empty and full
    task automatic test_random_mix();
        int target;
        int kind;
        int run_len;
        int key_mode;
        target = words_sent + RANDOM_ITEMS;
        while (words_sent < target) begin
            kind        = $urandom_range(0, 9);
            run_len     = $urandom_range(10, 80);
            key_mode    = $urandom_range(0, 2);
            src_gaps    = ($urandom_range(0, 4) != 0);
            sink_stalls = ($urandom_range(0, 4) != 0);
            for (int i = 0; i < run_len; i++) begin
                case (kind)
                    0, 1, 2, 3: begin
                        send_word($urandom_range(0, 1) ? ACT_DELETE : ACT_INSERT,
                                  pick_key(key_mode));
                    end
                    4, 5: begin
                        send_word($urandom_range(0, 7) == 0 ? ACT_DELETE : ACT_INSERT,
                                  pick_key(key_mode));
                    end
                    6, 7: begin
                        send_word($urandom_range(0, 7) == 0 ? ACT_INSERT : ACT_DELETE,
                                  pick_key(key_mode));
                    end
                    default: begin
                        send_word((i % 2) ? ACT_DELETE : ACT_INSERT, pick_key(key_mode));
                    end
                endcase
            end
        end
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        settle_phase();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_and_drain();
        test_random_mix();
        test_full_and_drain();
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("max_heap_priority_queue regression: pass");
        end else begin
            $display("max_heap_priority_queue regression: fail");
        end
        $finish;
    end

endmodule
